// ===== design/cbpc_pkg.sv =====
package cbpc_pkg;

   // Block geometry
   localparam int BLOCK_BYTES = 32;
   localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
   localparam int POS_W       = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam int BIT_W       = POS_W + 3;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_W     = $clog2(QUEUE_DEPTH);

   // Input mode codes
   localparam logic [2:0] MODE_LOAD_FIRST  = 3'd0;
   localparam logic [2:0] MODE_LOAD_SECOND = 3'd1;
   localparam logic [2:0] MODE_LOAD_CHAIN  = 3'd2;
   localparam logic [2:0] MODE_ENCRYPT     = 3'd3;
   localparam logic [2:0] MODE_DECRYPT     = 3'd4;

   typedef enum logic [2:0] {
      OP_LOAD_FIRST,
      OP_LOAD_SECOND,
      OP_LOAD_CHAIN,
      OP_ENCRYPT,
      OP_DECRYPT
   } op_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] index;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_last;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] index;
      logic [7:0] value;
   } cmd_type;

endpackage

// ===== design/cbpc_front.sv =====
module cbpc_front
   import cbpc_pkg::*;
(
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    push,
   output cmd_type push_cmd,
   input  logic    queue_full
);

   logic keep;

   // Hold the input while the queue has no room
   assign req_stall = queue_full;

   // Classify the mode; drop unused modes and chain bytes outside the block
   always_comb begin
      keep           = 1'b1;
      push_cmd.op    = OP_LOAD_FIRST;
      push_cmd.index = req_data.index;
      push_cmd.value = req_data.value;
      case (req_data.mode)
         MODE_LOAD_FIRST:  push_cmd.op = OP_LOAD_FIRST;
         MODE_LOAD_SECOND: push_cmd.op = OP_LOAD_SECOND;
         MODE_LOAD_CHAIN: begin
            push_cmd.op = OP_LOAD_CHAIN;
            keep        = (req_data.index < 8'(BLOCK_BYTES));
         end
         MODE_ENCRYPT:     push_cmd.op = OP_ENCRYPT;
         MODE_DECRYPT:     push_cmd.op = OP_DECRYPT;
         default:          keep        = 1'b0;
      endcase
   end

   assign push = req_valid && !queue_full && keep;

endmodule

// ===== design/cbpc_queue.sv =====
module cbpc_queue
   import cbpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_W-1:0]   wr_ptr_ff;
   logic [QUEUE_W-1:0]   rd_ptr_ff;
   logic [QUEUE_W:0]     count_ff;
   logic [QUEUE_W:0]     count_in;
   logic                 do_pop;

   assign full       = (count_ff == (QUEUE_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Advance pointers and store pushed items
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            slot_ff[wr_ptr_ff] <= push_cmd;
            wr_ptr_ff          <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ===== design/cbpc_back.sv =====
module cbpc_back
   import cbpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cmd_type head_cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] emit_ff;
   logic [BIT_W:0]   issue_ff;
   logic             iss_vld_ff;
   logic [BIT_W-1:0] kd_ff;
   logic             decrypt_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [7:0] chain_ff  [BLOCK_BYTES];
   logic [7:0] gather_ff [BLOCK_BYTES];
   logic [7:0] res_ff    [BLOCK_BYTES];

   logic [7:0] first_mem  [256];
   logic [7:0] second_mem [256];
   logic [7:0] t1_rd_ff;
   logic [7:0] t2_rd_ff;

   logic             issuing;
   logic [7:0]       tbl_addr;
   logic             in1;
   logic             in2;
   logic             p2_bit;
   logic [POS_W-1:0] g_byte;
   logic [2:0]       g_bit;
   logic             data_bit;
   logic [POS_W-1:0] w_byte;
   logic [2:0]       w_bit;
   logic             w_en;
   logic             out_free;
   logic             last_bit;

   assign pop       = (state_ff == ST_IDLE) && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Table read address follows the bit counter during a block pass
   assign issuing  = (state_ff == ST_RUN) && (issue_ff < (BIT_W+1)'(BLOCK_BITS));
   assign tbl_addr = 8'(issue_ff[BIT_W-1:0]);

   // Table memories: loads in idle, one read per cycle each during a pass
   always_ff @(posedge clock) begin
      if (pop && head_cmd.op == OP_LOAD_FIRST) begin
         first_mem[head_cmd.index] <= head_cmd.value;
      end
      if (pop && head_cmd.op == OP_LOAD_SECOND) begin
         second_mem[head_cmd.index] <= head_cmd.value;
      end
      t1_rd_ff <= first_mem[tbl_addr];
      t2_rd_ff <= second_mem[tbl_addr];
   end

   // Gather one bit of P2 from the chain and route the data bit
   always_comb begin
      in1    = ({1'b0, t1_rd_ff[7:3]} < 6'(BLOCK_BYTES));
      in2    = ({1'b0, t2_rd_ff[7:3]} < 6'(BLOCK_BYTES));
      p2_bit = in2 ? chain_ff[t2_rd_ff[POS_W+2:3]][t2_rd_ff[2:0]] : 1'b0;
      if (decrypt_ff) begin
         // Decrypt: XOR in place, then scatter to the table's target bit
         g_byte   = kd_ff[BIT_W-1:3];
         g_bit    = kd_ff[2:0];
         data_bit = gather_ff[g_byte][g_bit] ^ p2_bit;
         w_byte   = t1_rd_ff[POS_W+2:3];
         w_bit    = t1_rd_ff[2:0];
         w_en     = in1;
      end else begin
         // Encrypt: gather from the table's source bit, then XOR
         g_byte   = t1_rd_ff[POS_W+2:3];
         g_bit    = t1_rd_ff[2:0];
         data_bit = (in1 & gather_ff[g_byte][g_bit]) ^ p2_bit;
         w_byte   = kd_ff[BIT_W-1:3];
         w_bit    = kd_ff[2:0];
         w_en     = 1'b1;
      end
   end

   assign last_bit = iss_vld_ff && (kd_ff == BIT_W'(BLOCK_BITS - 1));

   // Sequencer: commands in idle, bit pass, chain update, byte emission
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         emit_ff      <= '0;
         issue_ff     <= '0;
         iss_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BLOCK_BYTES; i++) begin
            chain_ff[i] <= '0;
         end
      end else begin
         iss_vld_ff <= issuing;
         kd_ff      <= issue_ff[BIT_W-1:0];
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  case (head_cmd.op)
                     OP_LOAD_CHAIN: begin
                        chain_ff[head_cmd.index[POS_W-1:0]] <= head_cmd.value;
                     end
                     OP_ENCRYPT, OP_DECRYPT: begin
                        gather_ff[pos_ff] <= head_cmd.value;
                        if (pos_ff == POS_W'(BLOCK_BYTES - 1)) begin
                           pos_ff     <= '0;
                           decrypt_ff <= (head_cmd.op == OP_DECRYPT);
                           issue_ff   <= '0;
                           for (int i = 0; i < BLOCK_BYTES; i++) begin
                              res_ff[i] <= '0;
                           end
                           state_ff   <= ST_RUN;
                        end else begin
                           pos_ff <= pos_ff + 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_RUN: begin
               if (issuing) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               if (iss_vld_ff && w_en) begin
                  res_ff[w_byte][w_bit] <= data_bit;
               end
               if (last_bit) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               // The cipher block becomes the new chain block
               for (int i = 0; i < BLOCK_BYTES; i++) begin
                  chain_ff[i] <= decrypt_ff ? gather_ff[i] : res_ff[i];
               end
               emit_ff  <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.data_byte  <= res_ff[emit_ff];
                  rsp_data_ff.block_last <= (emit_ff == POS_W'(BLOCK_BYTES - 1));
                  emit_ff                <= emit_ff + 1'b1;
                  if (emit_ff == POS_W'(BLOCK_BYTES - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== design/chained_bit_permutation_cipher_top.sv =====
// Chained bit-permutation cipher. Table loads, chain byte loads and data bytes
// are taken by the back end only while it is idle; a four-entry command queue lets
// the input take a few items while a block is being worked on. The data byte that
// completes a block starts a pass (one read of each permutation table memory per
// output bit, through a registered read port) and a chain update, after which the
// block's bytes leave at up to one per cycle while the receiver does not stall.
// The work per block is set by the single read port of each table memory. Mode
// values 5 to 7 and chain bytes beyond the block are dropped at the input and
// produce no result.
module chained_bit_permutation_cipher_top
   import cbpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   cbpc_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   cbpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   cbpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== tb/chained_bit_permutation_cipher_top_tb.sv =====
module chained_bit_permutation_cipher_top_tb;
   import cbpc_pkg::*;

   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam int TABLE_DEPTH    = 256;
   localparam int TAIL_CYCLES    = 2 * (BLOCK_BITS + BLOCK_BYTES + 8);
   localparam int WATCHDOG_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   chained_bit_permutation_cipher_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Mirror of the cipher state
   logic [7:0]            first_perm  [TABLE_DEPTH];
   logic [7:0]            second_perm [TABLE_DEPTH];
   logic [BLOCK_BITS-1:0] chain_blk;
   logic [BLOCK_BITS-1:0] data_blk;
   int                    byte_pos;

   rsp_type due_bytes[$];
   int      mismatch_count = 0;
   int      send_idle_pct  = 0;
   int      rsp_stall_pct  = 0;
   int      quiet_cycles   = 0;
   rsp_type want;

   initial begin
      forever #6 clock = ~clock;
   end

   // Gather: output bit k takes source bit from the selected table
   function automatic logic [BLOCK_BITS-1:0] gather_perm(input bit use_second,
                                                        input logic [BLOCK_BITS-1:0] src);
      logic [BLOCK_BITS-1:0] dst;
      int s;
      dst = '0;
      for (int k = 0; k < BLOCK_BITS; k++) begin
         s = use_second ? second_perm[k % TABLE_DEPTH] : first_perm[k % TABLE_DEPTH];
         if ((s >> 3) < BLOCK_BYTES) dst[k] = src[s];
      end
      return dst;
   endfunction

   // Scatter through the first table; a later entry overwrites an earlier one
   function automatic logic [BLOCK_BITS-1:0] scatter_perm(input logic [BLOCK_BITS-1:0] src);
      logic [BLOCK_BITS-1:0] dst;
      int s;
      dst = '0;
      for (int k = 0; k < BLOCK_BITS; k++) begin
         s = first_perm[k % TABLE_DEPTH];
         if ((s >> 3) < BLOCK_BYTES) dst[s] = src[k];
      end
      return dst;
   endfunction

   // Update the mirror with one accepted item and queue the bytes it emits
   function automatic void absorb_item(input req_type item);
      logic [BLOCK_BITS-1:0] mask;
      logic [BLOCK_BITS-1:0] blk_out;
      rsp_type r;
      case (item.mode)
         MODE_LOAD_FIRST: first_perm[item.index] = item.value;
         MODE_LOAD_SECOND: second_perm[item.index] = item.value;
         MODE_LOAD_CHAIN: begin
            if (item.index < BLOCK_BYTES) chain_blk[item.index * 8 +: 8] = item.value;
         end
         MODE_ENCRYPT, MODE_DECRYPT: begin
            data_blk[byte_pos * 8 +: 8] = item.value;
            byte_pos++;
            if (byte_pos == BLOCK_BYTES) begin
               byte_pos = 0;
               mask = gather_perm(1'b1, chain_blk);
               if (item.mode == MODE_ENCRYPT) begin
                  blk_out   = gather_perm(1'b0, data_blk) ^ mask;
                  chain_blk = blk_out;
               end else begin
                  blk_out   = scatter_perm(data_blk ^ mask);
                  chain_blk = data_blk;
               end
               for (int i = 0; i < BLOCK_BYTES; i++) begin
                  r.data_byte  = blk_out[i * 8 +: 8];
                  r.block_last = (i == BLOCK_BYTES - 1);
                  due_bytes.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Offer one item, idling first at the current rate, and hold until taken
   task automatic send_item(input logic [2:0] mode, input logic [7:0] index,
                            input logic [7:0] value);
      req_type item;
      item.mode  = mode;
      item.index = index;
      item.value = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_item(item);
   endtask

   task automatic quiet_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the sender until every queued byte has come back
   task automatic wait_drained();
      quiet_req();
      while (due_bytes.size() != 0) @(posedge clock);
   endtask

   // Load both tables in full with fresh random bijections
   task automatic test_table_load();
      int perm [TABLE_DEPTH];
      int j;
      int t;
      for (int tab = 0; tab < 2; tab++) begin
         for (int i = 0; i < TABLE_DEPTH; i++) perm[i] = i;
         for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
            j       = $urandom_range(i, 0);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
         end
         for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(tab == 0 ? MODE_LOAD_FIRST : MODE_LOAD_SECOND, i[7:0], perm[i][7:0]);
      end
      quiet_req();
   endtask

   // Chain bytes at both ends, out-of-range chain bytes and unused modes
   task automatic test_chain_edges();
      send_item(MODE_LOAD_CHAIN, 8'd0, 8'hFF);
      send_item(MODE_LOAD_CHAIN, 8'(BLOCK_BYTES - 1), 8'h00);
      send_item(MODE_LOAD_CHAIN, 8'(BLOCK_BYTES), 8'hAA);
      send_item(MODE_LOAD_CHAIN, 8'hFF, 8'h55);
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
         send_item(m[2:0], 8'hFF, 8'hFF);
      quiet_req();
   endtask

   // Colliding table entries, extreme bytes, mixed modes ending in decrypt
   task automatic test_directed_block();
      logic [7:0] v;
      send_item(MODE_LOAD_FIRST, 8'd5, first_perm[6]);
      send_item(MODE_LOAD_SECOND, 8'd0, second_perm[TABLE_DEPTH - 1]);
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         case (i)
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = 8'h01;
            3:       v = 8'h80;
            default: v = 8'($urandom_range(255));
         endcase
         send_item((i % 2 == 1) ? MODE_DECRYPT : MODE_ENCRYPT, 8'($urandom_range(255)), v);
      end
      wait_drained();
   endtask

   // Mostly data streams, with chain loads, table rewrites and unused modes
   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      int done;
      int pick;
      done          = 0;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            send_item($urandom_range(1) ? MODE_ENCRYPT : MODE_DECRYPT,
                      8'($urandom_range(255)), 8'($urandom_range(255)));
            done++;
         end else if (pick < 86) begin
            send_item(MODE_LOAD_CHAIN,
                      ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(BLOCK_BYTES - 1)),
                      8'($urandom_range(255)));
            done++;
         end else if (pick < 93) begin
            send_item($urandom_range(1) ? MODE_LOAD_SECOND : MODE_LOAD_FIRST,
                      8'($urandom_range(255)), 8'($urandom_range(255)));
            done++;
         end else begin
            send_item(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
         end
      end
      quiet_req();
   endtask

   // Randomize receiver stall at the current rate
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Compare each taken byte with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_bytes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected byte: expected none, actual %h/%b",
                     $time, rsp_data.data_byte, rsp_data.block_last);
         end else begin
            want = due_bytes.pop_front();
            if (rsp_data.data_byte !== want.data_byte) begin
               mismatch_count++;
               $display("%0t: data_byte mismatch: expected %h, actual %h",
                        $time, want.data_byte, rsp_data.data_byte);
            end
            if (rsp_data.block_last !== want.block_last) begin
               mismatch_count++;
               $display("%0t: block_last mismatch: expected %b, actual %b",
                        $time, want.block_last, rsp_data.block_last);
            end
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("** chained_bit_permutation_cipher_top: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         first_perm[i]  = '0;
         second_perm[i] = '0;
      end
      chain_blk = '0;
      data_blk  = '0;
      byte_pos  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_load();
      test_chain_edges();
      test_directed_block();
      test_random_traffic(115, 0, 0);
      wait_drained();
      test_random_traffic(115, 83, 0);
      wait_drained();
      test_random_traffic(115, 0, 83);
      test_random_traffic(115, 20, 20);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && due_bytes.size() == 0) begin
         $display("** chained_bit_permutation_cipher_top: PASSED **");
      end else begin
         $display("** chained_bit_permutation_cipher_top: FAILED **");
      end
      $finish;
   end

endmodule
